### rtl/imhq_pkg.sv
// ----------------------------------------------------------------------------
// imhq_pkg
// Types, constants and state codes for the indexed min-heap queue.
// ----------------------------------------------------------------------------
package imhq_pkg;

    localparam int ITEMS     = 4096;
    localparam int KEY_BITS  = 32;
    localparam int ID_W      = 12;
    localparam int POS_W     = 13;
    localparam int STATUS_W  = 2;
    localparam int FUNC_W    = 2;

    localparam logic [FUNC_W-1:0] FUNC_UPSERT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EXTRACT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [ID_W-1:0]     item_id;
        logic [KEY_BITS-1:0] new_key;
    } imhq_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                was_queued;
        logic [ID_W-1:0]     out_item;
        logic [KEY_BITS-1:0] out_key;
        logic [POS_W-1:0]    queue_length;
        logic [KEY_BITS-1:0] top_key;
    } imhq_out_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_DECODE,
        S_EXT_RD,
        S_EXT_WAIT,
        S_EXT_DO,
        S_MOVE_RD,
        S_MOVE_WAIT,
        S_MOVE_WR,
        S_UP_RD,
        S_UP_WAIT,
        S_UP_CMP,
        S_DN_RD,
        S_DN_WAIT,
        S_DN_CMP,
        S_TOP_RD,
        S_TOP_WAIT,
        S_OUT
    } imhq_state_t;

endpackage

### rtl/imhq_slot_ram.sv
// ----------------------------------------------------------------------------
// imhq_slot_ram
// Heap slot store: item number and key per slot, one write and two reads.
// ----------------------------------------------------------------------------
module imhq_slot_ram
    import imhq_pkg::*;
(
    input  logic                aclk,
    input  logic                we,
    input  logic [POS_W-1:0]    waddr,
    input  logic [ID_W-1:0]     wdata_item,
    input  logic [KEY_BITS-1:0] wdata_key,
    input  logic [POS_W-1:0]    raddr_a,
    input  logic [POS_W-1:0]    raddr_b,
    output logic [ID_W-1:0]     rdata_a_item,
    output logic [KEY_BITS-1:0] rdata_a_key,
    output logic [ID_W-1:0]     rdata_b_item,
    output logic [KEY_BITS-1:0] rdata_b_key
);

    logic [ID_W+KEY_BITS-1:0] mem [0:ITEMS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= {wdata_item, wdata_key};
        end
        {rdata_a_item, rdata_a_key} <= mem[raddr_a];
        {rdata_b_item, rdata_b_key} <= mem[raddr_b];
    end

endmodule

### rtl/imhq_pos_ram.sv
// ----------------------------------------------------------------------------
// imhq_pos_ram
// Per-item back index: slot of each item, zero when not queued.
// ----------------------------------------------------------------------------
module imhq_pos_ram
    import imhq_pkg::*;
(
    input  logic             aclk,
    input  logic             we,
    input  logic [ID_W-1:0]  waddr,
    input  logic [POS_W-1:0] wdata,
    input  logic [ID_W-1:0]  raddr,
    output logic [POS_W-1:0] rdata
);

    logic [POS_W-1:0] mem [0:ITEMS-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/indexed_min_heap_queue.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue
// Indexed binary min-heap with insert/update, remove and extract-min.
// ----------------------------------------------------------------------------
// one transaction at a time: a new request is accepted only after the result
//   has been taken; each heap level of a sift is a read, a wait and a compare
// reset: a clearing pass zeroes every entry of the position store, during
//   which no transaction is accepted; length resets to zero
module indexed_min_heap_queue
    import imhq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  imhq_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output imhq_out_t m_data
);

    imhq_state_t state_reg, state_next;

    imhq_in_t         req_reg, req_next;
    logic [POS_W-1:0] len_reg, len_next;
    logic [POS_W-1:0] cur_reg, cur_next;      // sift position
    logic [ID_W-1:0]  ci_reg, ci_next;        // item at cur
    logic [KEY_BITS-1:0] ck_reg, ck_next;     // key at cur
    logic [1:0]       status_reg, status_next;
    logic             queued_reg, queued_next;
    logic [ID_W-1:0]  oitem_reg, oitem_next;
    logic [KEY_BITS-1:0] okey_reg, okey_next;
    logic             down_reg, down_next;    // run sift down after sift up
    logic [ID_W-1:0]  clr_reg, clr_next;
    logic             mv_reg, mv_next;
    imhq_out_t        out_reg, out_next;

    // slot ram
    logic             s_we;
    logic [POS_W-1:0] s_wa, s_ra, s_rb;
    logic [ID_W-1:0]  s_wi, ra_item, rb_item;
    logic [KEY_BITS-1:0] s_wk, ra_key, rb_key;
    // position ram
    logic             p_we;
    logic [ID_W-1:0]  p_wa, p_ra;
    logic [POS_W-1:0] p_wd, p_rd;

    imhq_slot_ram u_slot (
        .aclk(aclk), .we(s_we), .waddr(s_wa), .wdata_item(s_wi), .wdata_key(s_wk),
        .raddr_a(s_ra), .raddr_b(s_rb),
        .rdata_a_item(ra_item), .rdata_a_key(ra_key),
        .rdata_b_item(rb_item), .rdata_b_key(rb_key)
    );

    imhq_pos_ram u_pos (
        .aclk(aclk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
    );

    logic [POS_W-1:0] parent, lchild, rchild;
    logic             l_ok, r_ok, r_best;
    logic [KEY_BITS-1:0] bkey;
    logic [ID_W-1:0]  bitem;
    logic [POS_W-1:0] bpos;

    assign parent = cur_reg >> 1;
    assign lchild = {cur_reg[POS_W-2:0], 1'b0};
    assign rchild = {cur_reg[POS_W-2:0], 1'b1};

    always_comb begin
        l_ok   = !cur_reg[POS_W-1] && (lchild <= len_reg) && (ra_key < ck_reg);
        r_ok   = !cur_reg[POS_W-1] && (rchild <= len_reg);
        // ties go to the left child
        r_best = r_ok && (l_ok ? (rb_key < ra_key) : (rb_key < ck_reg));
        bkey   = r_best ? rb_key : ra_key;
        bitem  = r_best ? rb_item : ra_item;
        bpos   = r_best ? rchild : lchild;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            len_reg   <= '0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            clr_reg   <= clr_next;
        end
        req_reg    <= req_next;
        cur_reg    <= cur_next;
        ci_reg     <= ci_next;
        ck_reg     <= ck_next;
        status_reg <= status_next;
        queued_reg <= queued_next;
        oitem_reg  <= oitem_next;
        okey_reg   <= okey_next;
        down_reg   <= down_next;
        mv_reg     <= mv_next;
        out_reg    <= out_next;
    end

    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        len_next    = len_reg;
        cur_next    = cur_reg;
        ci_next     = ci_reg;
        ck_next     = ck_reg;
        status_next = status_reg;
        queued_next = queued_reg;
        oitem_next  = oitem_reg;
        okey_next   = okey_reg;
        down_next   = down_reg;
        clr_next    = clr_reg;
        mv_next     = mv_reg;
        out_next    = out_reg;
        s_we = 1'b0; s_wa = cur_reg; s_wi = ci_reg; s_wk = ck_reg;
        s_ra = cur_reg; s_rb = cur_reg;
        p_we = 1'b0; p_wa = ci_reg; p_wd = cur_reg; p_ra = req_reg.item_id;

        case (state_reg)
            S_CLEAR: begin
                p_we = 1'b1; p_wa = clr_reg; p_wd = '0;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                p_ra = s_data.item_id;
                if (s_valid) begin
                    req_next   = s_data;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                // position read data lands at end of this cycle
                state_next = S_DECODE;
            end
            S_DECODE: begin
                status_next = ST_DONE;
                queued_next = (p_rd != '0);
                oitem_next  = req_reg.item_id;
                okey_next   = '0;
                down_next   = 1'b0;
                state_next  = S_TOP_RD;
                case (req_reg.func)
                    FUNC_UPSERT: begin
                        ci_next   = req_reg.item_id;
                        ck_next   = req_reg.new_key;
                        if (p_rd != '0) begin
                            cur_next  = p_rd;
                            down_next = 1'b1;
                            state_next = S_UP_RD;
                        end else begin
                            cur_next   = len_reg + 1'b1;
                            len_next   = len_reg + 1'b1;
                            state_next = S_UP_RD;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (p_rd == '0) begin
                            status_next = ST_NOT_QUEUED;
                        end else begin
                            p_we = 1'b1; p_wa = req_reg.item_id; p_wd = '0;
                            len_next = len_reg - 1'b1;
                            cur_next = p_rd;
                            if (p_rd != len_reg) begin
                                down_next  = 1'b1;
                                state_next = S_MOVE_RD;
                            end
                        end
                    end
                    FUNC_EXTRACT: begin
                        if (len_reg == '0) begin
                            status_next = ST_EMPTY;
                            queued_next = 1'b0;
                            oitem_next  = '0;
                        end else begin
                            state_next = S_EXT_RD;
                        end
                    end
                    default: ;
                endcase
            end
            S_EXT_RD: begin
                s_ra = POS_W'(1); s_rb = len_reg;
                state_next = S_EXT_WAIT;
            end
            S_EXT_WAIT: begin
                s_ra = POS_W'(1); s_rb = len_reg;
                state_next = S_EXT_DO;
            end
            S_EXT_DO: begin
                oitem_next  = ra_item;
                okey_next   = ra_key;
                queued_next = 1'b1;
                p_we = 1'b1; p_wa = ra_item; p_wd = '0;
                len_next = len_reg - 1'b1;
                cur_next = POS_W'(1);
                ci_next  = rb_item;
                ck_next  = rb_key;
                if (len_reg > POS_W'(1)) begin
                    state_next = S_MOVE_WR;
                    mv_next    = (len_reg > POS_W'(2));
                end else begin
                    state_next = S_TOP_RD;
                end
            end
            S_MOVE_RD: begin
                s_ra = len_reg + 1'b1;   // old last slot
                state_next = S_MOVE_WAIT;
            end
            S_MOVE_WAIT: begin
                s_ra = len_reg + 1'b1;
                state_next = S_MOVE_WR;
                mv_next    = 1'b1;
            end
            S_MOVE_WR: begin
                if (req_reg.func == FUNC_EXTRACT) begin
                    // last item goes to the root, then sifts down if anything is below
                    s_we = 1'b1; p_we = 1'b1;
                    state_next = mv_reg ? S_DN_RD : S_TOP_RD;
                end else begin
                    ci_next = ra_item;
                    ck_next = ra_key;
                    state_next = S_UP_RD;
                end
            end
            S_UP_RD: begin
                // place current at cur, then fetch parent
                s_we = 1'b1; p_we = 1'b1;
                s_ra = parent;
                state_next = (cur_reg > POS_W'(1)) ? S_UP_WAIT
                           : (down_reg ? S_DN_RD : S_TOP_RD);
            end
            S_UP_WAIT: begin
                s_ra = parent;
                state_next = S_UP_CMP;
            end
            S_UP_CMP: begin
                if (ck_reg < ra_key) begin
                    // move parent down into cur
                    s_we = 1'b1; s_wa = cur_reg; s_wi = ra_item; s_wk = ra_key;
                    p_we = 1'b1; p_wa = ra_item; p_wd = cur_reg;
                    cur_next   = parent;
                    down_next  = 1'b0;
                    state_next = S_UP_RD;
                end else begin
                    state_next = down_reg ? S_DN_RD : S_TOP_RD;
                end
            end
            S_DN_RD: begin
                s_ra = lchild; s_rb = rchild;
                state_next = S_DN_WAIT;
            end
            S_DN_WAIT: begin
                s_ra = lchild; s_rb = rchild;
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (l_ok || r_best) begin
                    s_we = 1'b1; s_wa = cur_reg; s_wi = bitem; s_wk = bkey;
                    p_we = 1'b1; p_wa = bitem; p_wd = cur_reg;
                    cur_next   = bpos;
                    state_next = S_DN_RD;
                end else begin
                    s_we = 1'b1; p_we = 1'b1;
                    state_next = S_TOP_RD;
                end
            end
            S_TOP_RD: begin
                s_ra = POS_W'(1);
                state_next = S_TOP_WAIT;
            end
            S_TOP_WAIT: begin
                s_ra = POS_W'(1);
                state_next = S_OUT;
                out_next.status       = status_reg;
                out_next.was_queued   = queued_reg;
                out_next.out_item     = oitem_reg;
                out_next.out_key      = okey_reg;
                out_next.queue_length = len_reg;
                out_next.top_key      = (len_reg != '0) ? ra_key : '1;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### verif/indexed_min_heap_queue_test.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_test
// Self-checking bench for the indexed min-heap queue: drives insert/update,
// remove, extract and unused-code transactions with random gaps and stalls, predicts each
// result with a behavioral heap and compares every field in order.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_test;
    import imhq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
    localparam logic [KEY_BITS-1:0] KEY_INF = '1;

    class heap_scoreboard;
        logic [ID_W-1:0]     hp_item [1:ITEMS];
        logic [KEY_BITS-1:0] hp_key  [1:ITEMS];
        int unsigned         slot_of [ITEMS];
        int unsigned         count;
        imhq_out_t           pending [$];
        int                  errors;

        function new();
            for (int i = 0; i < ITEMS; i++) slot_of[i] = 0;
            count = 0;
            errors = 0;
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic [ID_W-1:0]     it;
            logic [KEY_BITS-1:0] k;
            it = hp_item[a]; k = hp_key[a];
            hp_item[a] = hp_item[b]; hp_key[a] = hp_key[b];
            hp_item[b] = it; hp_key[b] = k;
            slot_of[hp_item[a]] = a;
            slot_of[hp_item[b]] = b;
        endfunction

        function void sift_toward_root(int unsigned i);
            while (i > 1 && hp_key[i] < hp_key[i/2]) begin
                swap_slots(i, i/2);
                i = i / 2;
            end
        endfunction

        function void sift_toward_leaves(int unsigned i);
            int unsigned best;
            forever begin
                best = i;
                if (2*i <= count && hp_key[2*i] < hp_key[best]) best = 2*i;
                if (2*i+1 <= count && hp_key[2*i+1] < hp_key[best]) best = 2*i+1;
                if (best == i) break;
                swap_slots(best, i);
                i = best;
            end
        endfunction

        function void note_request(imhq_in_t req);
            imhq_out_t   r;
            int unsigned pos, last;
            pos = slot_of[req.item_id];
            r = '0;
            r.status = ST_DONE;
            r.was_queued = (pos != 0);
            r.out_item = req.item_id;
            case (req.func)
                FUNC_UPSERT: begin
                    if (pos != 0) begin
                        hp_key[pos] = req.new_key;
                        sift_toward_root(pos);
                        sift_toward_leaves(slot_of[req.item_id]);
                    end else if (count < ITEMS) begin
                        count++;
                        hp_item[count] = req.item_id;
                        hp_key[count] = req.new_key;
                        slot_of[req.item_id] = count;
                        sift_toward_root(count);
                    end
                end
                FUNC_REMOVE: begin
                    if (pos == 0) begin
                        r.status = ST_NOT_QUEUED;
                    end else begin
                        last = count;
                        slot_of[req.item_id] = 0;
                        count--;
                        if (pos != last) begin
                            hp_item[pos] = hp_item[last];
                            hp_key[pos] = hp_key[last];
                            slot_of[hp_item[pos]] = pos;
                            sift_toward_root(pos);
                            sift_toward_leaves(slot_of[hp_item[pos]]);
                        end
                    end
                end
                FUNC_EXTRACT: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                        r.was_queued = 0;
                        r.out_item = '0;
                    end else begin
                        r.out_item = hp_item[1];
                        r.out_key = hp_key[1];
                        r.was_queued = 1;
                        slot_of[hp_item[1]] = 0;
                        if (count > 1) begin
                            hp_item[1] = hp_item[count];
                            hp_key[1] = hp_key[count];
                            slot_of[hp_item[1]] = 1;
                        end
                        count--;
                        if (count > 1) sift_toward_leaves(1);
                    end
                end
                default: ;
            endcase
            r.queue_length = POS_W'(count);
            r.top_key = (count > 0) ? hp_key[1] : KEY_INF;
            pending = {pending, r};
        endfunction

        function void check_result(imhq_out_t got);
            imhq_out_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status)
                $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
            if (got.was_queued !== exp.was_queued)
                $display("%0t: was_queued exp %0d got %0d", $time,
                         exp.was_queued, got.was_queued);
            if (got.out_item !== exp.out_item)
                $display("%0t: out_item exp %0d got %0d", $time, exp.out_item, got.out_item);
            if (got.out_key !== exp.out_key)
                $display("%0t: out_key exp %h got %h", $time, exp.out_key, got.out_key);
            if (got.queue_length !== exp.queue_length)
                $display("%0t: queue_length exp %0d got %0d", $time,
                         exp.queue_length, got.queue_length);
            if (got.top_key !== exp.top_key)
                $display("%0t: top_key exp %h got %h", $time, exp.top_key, got.top_key);
            if (got !== exp) errors++;
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    imhq_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    imhq_out_t m_data;

    heap_scoreboard board;
    bit        sending_done;
    imhq_in_t  reqs [$];

    indexed_min_heap_queue dut (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // ids drawn mostly from a small pool so that updates and removes hit queued items
    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 9))
            0: return ID_W'($urandom);
            default: return ID_W'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key();
        case ($urandom_range(0, 7))
            0: return KEY_INF;
            1: return '0;
            2: return KEY_BITS'($urandom_range(0, 15));
            default: return KEY_BITS'($urandom);
        endcase
    endfunction

    function automatic imhq_in_t make_req(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                                          logic [KEY_BITS-1:0] k);
        imhq_in_t r;
        r.func = f; r.item_id = id; r.new_key = k;
        return r;
    endfunction

    // valid drops only for a gap, so back-to-back items keep it high
    task automatic send_req(imhq_in_t req);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        board.note_request(req);
    endtask

    // directed opening
    initial begin
        reqs = {reqs, make_req(FUNC_EXTRACT, 12'd5, 32'd0)};
        reqs = {reqs, make_req(FUNC_REMOVE, 12'd7, 32'd0)};
        reqs = {reqs, make_req(FUNC_UPSERT, 12'd4095, KEY_INF)};
        reqs = {reqs, make_req(FUNC_UPSERT, 12'd0, 32'd0)};
        reqs = {reqs, make_req(FUNC_UPSERT, 12'd10, 32'd100)};
        reqs = {reqs, make_req(FUNC_UPSERT, 12'd11, 32'd100)};
        reqs = {reqs, make_req(FUNC_UPSERT, 12'd12, 32'd50)};
        reqs = {reqs, make_req(FUNC_UPSERT, 12'd13, 32'd100)};
        reqs = {reqs, make_req(FUNC_UPSERT, 12'd10, 32'd1)};
        reqs = {reqs, make_req(FUNC_UPSERT, 12'd0, 32'hFFFF_FFFE)};
        reqs = {reqs, make_req(FUNC_NOP, 12'd10, 32'hA5A5_A5A5)};
        reqs = {reqs, make_req(FUNC_NOP, 12'd99, 32'd0)};
        reqs = {reqs, make_req(FUNC_REMOVE, 12'd12, 32'd0)};
        reqs = {reqs, make_req(FUNC_REMOVE, 12'd12, 32'd0)};
        reqs = {reqs, make_req(FUNC_REMOVE, 12'd4095, 32'd0)};
        for (int i = 0; i < 6; i++)
            reqs = {reqs, make_req(FUNC_EXTRACT, 12'hFFF, 32'd0)};
    end

    initial begin
        imhq_in_t req;
        board = new();
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        sending_done = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (reqs[i]) send_req(reqs[i]);
        for (int n = 0; n < 1530; n++) begin
            // insert-heavy phases grow the heap, then extract-heavy phases drain it
            if ((n / 200) % 2 == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: req = make_req(FUNC_UPSERT, pick_id(), pick_key());
                    6, 7: req = make_req(FUNC_REMOVE, pick_id(), KEY_BITS'($urandom));
                    8: req = make_req(FUNC_EXTRACT, ID_W'($urandom), KEY_BITS'($urandom));
                    default: req = make_req(FUNC_NOP, ID_W'($urandom), KEY_BITS'($urandom));
                endcase
            end else begin
                case ($urandom_range(0, 9))
                    0, 1: req = make_req(FUNC_UPSERT, pick_id(), pick_key());
                    2, 3: req = make_req(FUNC_REMOVE, pick_id(), KEY_BITS'($urandom));
                    default: req = make_req(FUNC_EXTRACT, ID_W'($urandom),
                                            KEY_BITS'($urandom));
                endcase
            end
            send_req(req);
        end
        s_valid <= 1'b0;
        sending_done = 1;
    end

    // receiver, with one long hold-off while the sender keeps offering
    initial begin
        int wait_cycles;
        int handled;
        m_ready = 0;
        handled = 0;
        @(posedge aresetn);
        forever begin
            if (handled == 300) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            wait_cycles = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_result(m_data);
            handled++;
        end
    end

    initial begin
        wait (sending_done);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

### files.f
rtl/imhq_pkg.sv
rtl/imhq_slot_ram.sv
rtl/imhq_pos_ram.sv
rtl/indexed_min_heap_queue.sv
verif/indexed_min_heap_queue_test.sv
